@@ design/fim_pkg.sv @@
// Shared types and constants for the frame interval monitor.
`default_nettype none
package fim_pkg;

	localparam int unsigned STAMP_W    = 64;
	localparam int unsigned IVAL_W     = 32;
	localparam int unsigned RATE_W     = 16;
	localparam int unsigned TPS_W      = 32;
	localparam int unsigned ACC_W      = 33;
	localparam int unsigned OUT_DATA_W = 144;

	localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_STOP    = 2'd2,
		ACT_RESUME  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CMP,
		ST_UPD,
		ST_DSTART,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec_tick;
		logic exec_other;
		logic compare;
		logic update;
		logic div_start;
		logic div_clear;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic window_empty;
		logic div_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

@@ design/fim_ctrl.sv @@
// Sequencing state machine for the frame interval monitor.
`default_nettype none
module fim_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  fim_pkg::status_t status,
	output fim_pkg::cmd_t    cmd
);
	import fim_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_tick) begin
					cmd.exec_tick = 1'b1;
					state_nx      = ST_CMP;
				end else begin
					cmd.exec_other = 1'b1;
					state_nx       = ST_OUT;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_nx    = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_nx   = ST_DSTART;
			end
			ST_DSTART: begin
				if (status.window_empty) begin
					cmd.div_clear = 1'b1;
					state_nx      = ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/fim_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fim_div #(
	parameter int unsigned DW = 39,
	parameter int unsigned VW = 7
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  wire  [DW-1:0] dividend,
	input  wire  [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;
	logic [VW:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

@@ design/fim_datapath.sv @@
// Interval, window, frame-rate and output registers of the frame interval monitor.
`default_nettype none
module fim_datapath #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  fim_pkg::cmd_t                      cmd,
	output fim_pkg::status_t                   status,
	input  wire  [63:0]                        s_tdata,
	input  wire  [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [fim_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire                                cfg_we,
	input  wire  [fim_pkg::TPS_W-1:0]          cfg_wdata
);
	import fim_pkg::*;

	localparam int unsigned HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W  = IVAL_W + CNT_W;

	logic [IVAL_W-1:0]  win_mem [WINDOW_DEPTH];
	logic [IVAL_W-1:0]  rd_q;

	logic [TPS_W-1:0]   tps_q;
	action_t            action_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] start_q;
	logic [IVAL_W-1:0]  iv_q;
	logic               take_q;
	logic [HEAD_W-1:0]  head_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [IVAL_W-1:0]  mean_q;
	logic [RATE_W-1:0]  fts_q;
	logic [ACC_W-1:0]   acc_q;
	logic [RATE_W-1:0]  rate_q;
	logic               stopped_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [STAMP_W-1:0] raw;
	logic [IVAL_W-1:0]  iv_sat;
	logic [IVAL_W-1:0]  diff;
	logic [RATE_W-1:0]  fts_nx;
	logic [ACC_W-1:0]   acc_nx;
	logic               full;
	logic [SUM_W-1:0]   sum_nx;
	logic [HEAD_W-1:0]  head_nx;
	logic [SUM_W-1:0]   quo;
	logic               div_done;

	assign raw    = stamp_q - last_q;
	assign iv_sat = (|raw[STAMP_W-1:IVAL_W]) ? '1 : raw[IVAL_W-1:0];
	assign diff   = (iv_q >= mean_q) ? (iv_q - mean_q) : (mean_q - iv_q);
	assign fts_nx = (fts_q == '1) ? fts_q : fts_q + 1'b1;
	assign acc_nx = acc_q + ACC_W'(iv_q);
	assign full   = count_q == CNT_W'(WINDOW_DEPTH);
	assign sum_nx = sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(iv_q);
	assign head_nx = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;

	fim_div #(
		.DW(SUM_W),
		.VW(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q),
		.divisor (count_q),
		.quotient(quo),
		.done    (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			rd_q <= win_mem[head_q];
		end
		if (cmd.update && take_q) begin
			win_mem[head_q] <= iv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action_t'(s_tuser);
			stamp_q  <= s_tdata;
		end
		if (cmd.exec_tick) begin
			iv_q <= iv_sat;
		end else if (cmd.exec_other) begin
			iv_q <= '0;
		end
		if (cmd.compare) begin
			take_q <= {1'b0, diff} < {1'b0, tps_q};
		end
		if (cmd.out_load) begin
			out_data_q <= {stamp_q - start_q, rate_q, iv_q, mean_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= TPS_RESET;
			last_q      <= '0;
			start_q     <= '0;
			head_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			mean_q      <= '0;
			fts_q       <= '0;
			acc_q       <= '0;
			rate_q      <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			if (cmd.exec_tick) begin
				last_q <= stamp_q;
			end
			if (cmd.exec_other) begin
				case (action_q)
					ACT_RESTART: begin
						last_q    <= stamp_q;
						start_q   <= stamp_q;
						head_q    <= '0;
						count_q   <= '0;
						sum_q     <= '0;
						mean_q    <= '0;
						fts_q     <= '0;
						acc_q     <= '0;
						rate_q    <= '0;
						stopped_q <= 1'b0;
					end
					ACT_STOP: begin
						stopped_q <= 1'b1;
					end
					ACT_RESUME: begin
						if (stopped_q) begin
							last_q    <= stamp_q;
							stopped_q <= 1'b0;
						end
					end
					default: begin
						stopped_q <= stopped_q;
					end
				endcase
			end
			if (cmd.compare) begin
				if (acc_nx > ACC_W'(tps_q)) begin
					rate_q <= fts_nx;
					fts_q  <= '0;
					acc_q  <= '0;
				end else begin
					fts_q <= fts_nx;
					acc_q <= acc_nx;
				end
			end
			if (cmd.update && take_q) begin
				sum_q  <= sum_nx;
				head_q <= head_nx;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.div_clear) begin
				mean_q <= '0;
			end else if (div_done) begin
				mean_q <= quo[IVAL_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.is_tick      = action_q == ACT_TICK;
	assign status.window_empty = count_q == '0;
	assign status.div_done     = div_done;
	assign status.out_free     = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ design/frame_interval_monitor_unit.sv @@
// Top level of the frame interval monitor.
//
// Takes one timestamped action at a time and returns one result transaction for each.
// Restart, stop and resume go from capture through execution straight to the output
// register. A tick passes compare and window update, then the bit-serial divider that
// forms the window mean, one quotient bit per cycle over the width of the window sum,
// 32 + clog2(WINDOW_DEPTH+1) bits. A tick that leaves the window empty skips the
// divider. The result sits in an output register, so the next transaction is accepted
// while a result waits to be taken.
// The interval window is a single-port memory with no clearing pass; restart only resets
// its fill count, write pointer and running sum.
`default_nettype none
module frame_interval_monitor_unit #(
	parameter int unsigned WINDOW_DEPTH = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [63:0]  s_tdata,   // timestamp[63:0]
	input  wire  [1:0]   s_tuser,   // action[1:0]
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [143:0] m_tdata,   // average_interval[31:0], last_interval[63:32],
	                                // frame_rate[79:64], time_since_start[143:80]
	input  wire          cfg_we,
	input  wire  [31:0]  cfg_wdata  // ticks_per_second
);
	import fim_pkg::*;

	cmd_t    cmd;
	status_t status;

	fim_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	fim_datapath #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

endmodule
`default_nettype wire

@@ design/fim_checker.sv @@
// Port-level checks for the frame interval monitor, bound to the top level.
`default_nettype none
module fim_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_tvalid,
	input wire         s_tready,
	input wire [1:0]   s_tuser,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [143:0] m_tdata
);
	import fim_pkg::*;

	logic in_txn;

	assign in_txn = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_txn |=> !s_tready)
		else $error("transaction accepted while another is in flight");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_txn && !m_tvalid && s_tuser == ACT_RESTART |-> ##3 m_tvalid && m_tdata == '0)
		else $error("restart result not all zero");

	a_nontick_interval: assert property (@(posedge clk) disable iff (!arst_n)
		in_txn && !m_tvalid && s_tuser != ACT_TICK |-> ##3 m_tvalid && m_tdata[63:32] == '0)
		else $error("non-tick result carries an interval");

endmodule

bind frame_interval_monitor_unit fim_checker u_fim_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

@@ tb/sv/frame_interval_monitor_unit_test.sv @@
// Self-checking bench for the frame interval monitor: directed table, then randomised phases.
module frame_interval_monitor_unit_test;
	import fim_pkg::*;

	localparam int unsigned DEPTH          = 64;
	localparam int unsigned DIR_N          = 19;
	localparam int unsigned PHASES         = 8;
	localparam int unsigned PHASE_ITEMS    = 125;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [63:0] DIR_BASE       = 64'hA5A5_A5A5_5A5A_5A5A;
	localparam logic [63:0] ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [STAMP_W-1:0] time_since_start;
		logic [RATE_W-1:0]  frame_rate;
		logic [IVAL_W-1:0]  last_interval;
		logic [IVAL_W-1:0]  average_interval;
	} fim_result_t;

	typedef struct {
		action_t            act;
		logic [STAMP_W-1:0] stamp;
		bit                 typed;
		fim_result_t        want;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [143:0] m_tdata;
	logic         cfg_we = 1'b0;
	logic [31:0]  cfg_wdata = '0;

	frame_interval_monitor_unit #(.WINDOW_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [TPS_W-1:0]   tps = TPS_RESET;
	logic [STAMP_W-1:0] prev_stamp = '0;
	logic [STAMP_W-1:0] origin_stamp = '0;
	logic [IVAL_W-1:0]  ring [DEPTH];
	int unsigned        ring_head = 0;
	int unsigned        ring_fill = 0;
	logic [63:0]        ring_total = '0;
	logic [IVAL_W-1:0]  avg_now = '0;
	logic [RATE_W-1:0]  frame_tally = '0;
	logic [63:0]        elapsed = '0;
	logic [RATE_W-1:0]  rate_hold = '0;
	bit                 halted = 1'b0;

	fim_result_t expected_results [$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned tx_gap_max = 6;
	int unsigned rx_gap_max = 6;
	stim_row_t   dir_rows [DIR_N];

	task automatic predict(input action_t act, input logic [STAMP_W-1:0] stamp,
			output fim_result_t res);
		logic [63:0]       span;
		logic [IVAL_W-1:0] iv;
		logic [IVAL_W-1:0] dev;
		int unsigned       slot;
		iv = '0;
		case (act)
			ACT_TICK: begin
				span = stamp - prev_stamp;
				iv = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
				prev_stamp = stamp;
				dev = (iv >= avg_now) ? iv - avg_now : avg_now - iv;
				if (dev < tps) begin
					slot = ring_head;
					if (ring_fill >= DEPTH)
						ring_total -= {32'b0, ring[slot]};
					else
						ring_fill++;
					ring[slot] = iv;
					ring_total += {32'b0, iv};
					ring_head = (slot + 1) % DEPTH;
				end
				if (frame_tally != 16'hFFFF)
					frame_tally++;
				elapsed += {32'b0, iv};
				if (elapsed > {32'b0, tps}) begin
					rate_hold = frame_tally;
					frame_tally = '0;
					elapsed = '0;
				end
				if (ring_fill > 0)
					avg_now = IVAL_W'(ring_total / ring_fill);
				else
					avg_now = '0;
			end
			ACT_RESTART: begin
				prev_stamp = stamp;
				origin_stamp = stamp;
				ring_head = 0;
				ring_fill = 0;
				ring_total = '0;
				avg_now = '0;
				frame_tally = '0;
				elapsed = '0;
				rate_hold = '0;
				halted = 1'b0;
			end
			ACT_STOP: halted = 1'b1;
			ACT_RESUME: begin
				if (halted) begin
					prev_stamp = stamp;
					halted = 1'b0;
				end
			end
		endcase
		res.average_interval = avg_now;
		res.last_interval    = iv;
		res.frame_rate       = rate_hold;
		res.time_since_start = stamp - origin_stamp;
	endtask

	task automatic send_item(input action_t act, input logic [STAMP_W-1:0] stamp,
			input bit typed, input fim_result_t typed_res);
		fim_result_t res;
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= stamp;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict(act, stamp, res);
		expected_results.push_back(typed ? typed_res : res);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_ticks_per_second(input logic [TPS_W-1:0] value);
		wait_for_results();
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		tps = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_result(input fim_result_t got);
		fim_result_t want;
		if (expected_results.size() == 0) begin
			$error("result transaction with no pending expectation: %h", got);
			mismatches++;
		end else begin
			want = expected_results.pop_front();
			if (got.average_interval !== want.average_interval) begin
				$error("average_interval: expected %0d, got %0d",
					want.average_interval, got.average_interval);
				mismatches++;
			end
			if (got.last_interval !== want.last_interval) begin
				$error("last_interval: expected %0d, got %0d",
					want.last_interval, got.last_interval);
				mismatches++;
			end
			if (got.frame_rate !== want.frame_rate) begin
				$error("frame_rate: expected %0d, got %0d",
					want.frame_rate, got.frame_rate);
				mismatches++;
			end
			if (got.time_since_start !== want.time_since_start) begin
				$error("time_since_start: expected %h, got %h",
					want.time_since_start, got.time_since_start);
				mismatches++;
			end
		end
	endtask

	initial begin : result_sink
		int unsigned hold;
		forever begin
			hold = $urandom_range(0, rx_gap_max);
			@(negedge clk);
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_result(fim_result_t'(m_tdata));
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [TPS_W-1:0]   phase_tps [PHASES];
		logic [STAMP_W-1:0] now;
		fim_result_t        blank;
		int unsigned        base;
		int unsigned        jit;
		int unsigned        r;
		action_t            act;

		blank = '0;
		dir_rows[0]  = '{ACT_TICK,    64'd0,     1'b1, blank};
		dir_rows[1]  = '{ACT_TICK,    ALL_ONES,  1'b1, {ALL_ONES, 16'd2, 32'hFFFF_FFFF, 32'd0}};
		dir_rows[2]  = '{ACT_TICK,    64'd5,     1'b1, {64'd5, 16'd2, 32'd6, 32'd3}};
		dir_rows[3]  = '{ACT_STOP,    64'd100,   1'b1, {64'd100, 16'd2, 32'd0, 32'd3}};
		dir_rows[4]  = '{ACT_TICK,    64'd200,   1'b0, blank};
		dir_rows[5]  = '{ACT_RESUME,  64'd300,   1'b0, blank};
		dir_rows[6]  = '{ACT_RESUME,  64'd400,   1'b0, blank};
		dir_rows[7]  = '{ACT_TICK,    64'd410,   1'b0, blank};
		dir_rows[8]  = '{ACT_RESTART, DIR_BASE,  1'b1, blank};
		dir_rows[9]  = '{ACT_TICK,    DIR_BASE + 64'h0_FFFF_FFFF, 1'b0, blank};
		dir_rows[10] = '{ACT_TICK,    DIR_BASE + 64'h1_FFFF_FFFF, 1'b0, blank};
		dir_rows[11] = '{ACT_STOP,    DIR_BASE + 64'h2_0000_0000, 1'b0, blank};
		dir_rows[12] = '{ACT_STOP,    DIR_BASE + 64'h2_0000_0001, 1'b0, blank};
		dir_rows[13] = '{ACT_TICK,    DIR_BASE + 64'h2_0000_0010, 1'b0, blank};
		dir_rows[14] = '{ACT_RESUME,  DIR_BASE + 64'h2_0000_0100, 1'b0, blank};
		dir_rows[15] = '{ACT_TICK,    DIR_BASE + 64'h2_0000_0164, 1'b0, blank};
		dir_rows[16] = '{ACT_RESTART, ALL_ONES,  1'b1, blank};
		dir_rows[17] = '{ACT_TICK,    64'd0,     1'b0, blank};
		dir_rows[18] = '{ACT_TICK,    64'h8000_0000_0000_0000, 1'b0, blank};

		phase_tps[0] = 32'd0;
		phase_tps[1] = 32'd1;
		phase_tps[2] = 32'hFFFF_FFFF;
		phase_tps[3] = 32'd1000;
		phase_tps[4] = $urandom_range(2, 5000);
		phase_tps[5] = $urandom;
		phase_tps[6] = 32'd250;
		phase_tps[7] = $urandom_range(2, 100);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_item(dir_rows[i].act, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].want);

		now = 64'h8000_0000_0000_0000;
		for (int ph = 0; ph < PHASES; ph++) begin
			set_ticks_per_second(phase_tps[ph]);
			tx_gap_max = (ph == 3) ? 0 : 6;
			rx_gap_max = (ph == 3 || ph == 5) ? 0 : 6;
			if (tps <= 1) begin
				base = $urandom_range(0, 3);
				jit  = $urandom_range(0, 1) * 3;
			end else if (tps > 32'd2_000_000) begin
				base = $urandom_range(1, tps - 32'd1_000_000);
				jit  = $urandom_range(0, 1_000_000);
			end else begin
				base = $urandom_range(1, (tps > 4000) ? 4000 : tps - 1);
				jit  = $urandom_range(0, tps / 2);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == 60)
					wait_for_results();
				r = $urandom_range(0, 99);
				if (r < 82) begin
					act = ACT_TICK;
					now = now + base + $urandom_range(0, jit);
				end else if (r < 85) begin
					act = ACT_TICK;
					now = {$urandom, $urandom};
				end else if (r < 88) begin
					act = ACT_TICK;
					now = now - $urandom_range(1, 5000);
				end else if (r == 88) begin
					act = ACT_RESTART;
					now = $urandom_range(0, 1) ? {$urandom, $urandom} : now + $urandom_range(0, 100);
				end else if (r < 94) begin
					act = ACT_STOP;
					now = now + $urandom_range(0, base);
				end else begin
					act = ACT_RESUME;
					now = now + $urandom_range(0, base);
				end
				send_item(act, now, 1'b0, blank);
			end
		end

		wait_for_results();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ frame_interval_monitor_unit.f @@
design/fim_pkg.sv
design/fim_ctrl.sv
design/fim_div.sv
design/fim_datapath.sv
design/frame_interval_monitor_unit.sv
design/fim_checker.sv
tb/sv/frame_interval_monitor_unit_test.sv
